FILE: sv/mcpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpr_pkg
// Shared types and constants for the multichannel power ramp.
// ----------------------------------------------------------------------------
package mcpr_pkg;

	localparam int LEVEL_W      = 7;
	localparam int ACC_W        = 16;
	localparam int TICK_W       = 16;
	localparam int FRAC_BITS    = 9;
	localparam int REPORT_CH    = 4;
	localparam int NUM_CH_DEF   = 4;
	localparam int DIV_CNT_W    = $clog2(ACC_W + 1);

	localparam logic [LEVEL_W-1:0] MAX_LEVEL  = 7'd100;
	localparam logic [TICK_W-1:0]  TICKS_RST  = 16'd100;
	localparam logic [ACC_W-1:0]   ACC_MAX    = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_RISE_TICKS = 1'b0;
	localparam logic CFG_FALL_TICKS = 1'b1;

	typedef enum logic [3:0] {
		ACT_INC_ONE   = 4'd0,
		ACT_DEC_ONE   = 4'd1,
		ACT_INC_ALL   = 4'd2,
		ACT_DEC_ALL   = 4'd3,
		ACT_PREP_RISE = 4'd4,
		ACT_PREP_FALL = 4'd5,
		ACT_RISE_TICK = 4'd6,
		ACT_FALL_TICK = 4'd7,
		ACT_APPLY     = 4'd8,
		ACT_SET_ALL   = 4'd9
	} action_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] duty;
		logic [ACC_W-1:0]   acc;
		logic [ACC_W-1:0]   rise_inc;
		logic [ACC_W-1:0]   fall_dec;
	} chan_t;

	// per-channel qualifiers handed to the update logic
	typedef struct packed {
		logic sel;
		logic en;
	} chan_ctl_t;

endpackage

FILE: sv/mcpr_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpr_serial_div
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module mcpr_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mcpr_pkg::ACC_W-1:0]  dividend,
	input  logic [mcpr_pkg::ACC_W-1:0]  divisor,
	output logic                        done,
	output logic [mcpr_pkg::ACC_W-1:0]  quotient
);

	logic [mcpr_pkg::ACC_W:0]         rem_q;
	logic [mcpr_pkg::ACC_W-1:0]       quo_q;
	logic [mcpr_pkg::ACC_W-1:0]       div_q;
	logic [mcpr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             done_q;
	logic [mcpr_pkg::ACC_W:0]         trial;
	logic                             fits;

	assign trial = {rem_q[mcpr_pkg::ACC_W-1:0], quo_q[mcpr_pkg::ACC_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= mcpr_pkg::DIV_CNT_W'(mcpr_pkg::ACC_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == mcpr_pkg::DIV_CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[mcpr_pkg::ACC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/mcpr_chan_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpr_chan_alu
// Next state of one channel for every action but the step division.
// ----------------------------------------------------------------------------
module mcpr_chan_alu (
	input  mcpr_pkg::action_t                 op,
	input  mcpr_pkg::chan_ctl_t               ctl,
	input  logic [mcpr_pkg::LEVEL_W-1:0]      level,
	input  mcpr_pkg::chan_t                   cur,
	output mcpr_pkg::chan_t                   nxt,
	output logic                              beep
);

	logic [mcpr_pkg::ACC_W:0]        sum;
	logic [mcpr_pkg::ACC_W-1:0]      acc_up;
	logic [mcpr_pkg::ACC_W-1:0]      acc_dn;
	logic [mcpr_pkg::LEVEL_W-1:0]    lvl_up;
	logic [mcpr_pkg::LEVEL_W-1:0]    lvl_dn;

	assign sum    = {1'b0, cur.acc} + {1'b0, cur.rise_inc};
	assign acc_up = sum[mcpr_pkg::ACC_W] ? mcpr_pkg::ACC_MAX : sum[mcpr_pkg::ACC_W-1:0];
	assign acc_dn = (cur.acc > cur.fall_dec) ? (cur.acc - cur.fall_dec) : '0;
	assign lvl_up = acc_up[mcpr_pkg::ACC_W-1:mcpr_pkg::FRAC_BITS];
	assign lvl_dn = acc_dn[mcpr_pkg::ACC_W-1:mcpr_pkg::FRAC_BITS];

	always_comb begin
		nxt  = cur;
		beep = 1'b0;
		case (op)
			mcpr_pkg::ACT_INC_ONE, mcpr_pkg::ACT_INC_ALL: begin
				if (ctl.sel || op == mcpr_pkg::ACT_INC_ALL) begin
					if (cur.target < mcpr_pkg::MAX_LEVEL) begin
						nxt.target = cur.target + 1'b1;
					end else begin
						nxt.target = mcpr_pkg::MAX_LEVEL;
						beep       = 1'b1;
					end
				end
			end
			mcpr_pkg::ACT_DEC_ONE, mcpr_pkg::ACT_DEC_ALL: begin
				if (ctl.sel || op == mcpr_pkg::ACT_DEC_ALL) begin
					if (cur.target != '0)
						nxt.target = cur.target - 1'b1;
					else
						beep = 1'b1;
				end
			end
			mcpr_pkg::ACT_PREP_RISE: begin
				nxt.acc = '0;
			end
			mcpr_pkg::ACT_PREP_FALL: begin
				nxt.acc = {cur.duty, {mcpr_pkg::FRAC_BITS{1'b0}}};
			end
			mcpr_pkg::ACT_RISE_TICK: begin
				if (ctl.en) begin
					nxt.acc = acc_up;
					// duty only follows while the ramp stays at or below target
					if (lvl_up <= cur.target)
						nxt.duty = lvl_up;
				end
			end
			mcpr_pkg::ACT_FALL_TICK: begin
				nxt.acc  = acc_dn;
				nxt.duty = (lvl_dn > mcpr_pkg::MAX_LEVEL) ? mcpr_pkg::MAX_LEVEL : lvl_dn;
			end
			mcpr_pkg::ACT_APPLY: begin
				if (ctl.en)
					nxt.duty = cur.target;
			end
			mcpr_pkg::ACT_SET_ALL: begin
				nxt.duty = (level > mcpr_pkg::MAX_LEVEL) ? mcpr_pkg::MAX_LEVEL : level;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

FILE: sv/multichannel_power_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_power_ramp
// Soft-start ramp controller for NUM_CHANNELS PWM duty levels.
// ----------------------------------------------------------------------------
// One request is handled at a time, channel by channel. Actions other than
// prepare rise and prepare fall pass each channel through S_CHAN and then
// register the result from S_DONE; prepare rise and prepare fall also go
// through the single bit-serial divider that all channels share (per channel
// it is loaded, works through its 16 quotient bits and hands the quotient
// back). The input reopens in the same cycle that the result is registered,
// and a new request is taken while the previous result still waits on
// out_stall. A tick register written with zero divides as one.
module multichannel_power_ramp #(
	parameter int NUM_CHANNELS = mcpr_pkg::NUM_CH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_index,
	input  logic [mcpr_pkg::TICK_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3:0]                    action,
	input  logic [1:0]                    channel,
	input  logic [3:0]                    enable_mask,
	input  logic [mcpr_pkg::LEVEL_W-1:0]  level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch0,
	output logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch1,
	output logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch2,
	output logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch3,
	output logic [3:0]                    active_mask,
	output logic                          beep
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CMP_W = (CH_W > 2) ? CH_W : 2;
	localparam int EXT_W = (NUM_CHANNELS > 4) ? NUM_CHANNELS : 4;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHAN,
		S_DIV,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [CH_W-1:0]                 ch_q;
	mcpr_pkg::action_t               act_q;
	logic [1:0]                      chan_sel_q;
	logic [3:0]                      mask_q;
	logic [mcpr_pkg::LEVEL_W-1:0]    level_q;
	logic                            beep_acc_q;
	logic [mcpr_pkg::TICK_W-1:0]     rise_ticks_q;
	logic [mcpr_pkg::TICK_W-1:0]     fall_ticks_q;

	logic                            out_valid_q;
	logic [mcpr_pkg::LEVEL_W-1:0]    duty_out_q [mcpr_pkg::REPORT_CH];
	logic [3:0]                      active_q;
	logic                            beep_q;

	mcpr_pkg::chan_t                 chans_q [NUM_CHANNELS];
	mcpr_pkg::chan_t                 cur;
	mcpr_pkg::chan_t                 nxt;
	mcpr_pkg::chan_ctl_t             ctl;
	logic                            alu_beep;
	logic [EXT_W-1:0]                mask_ext;
	logic                            is_div;
	logic                            last_ch;
	logic                            div_start;
	logic                            div_done;
	logic [mcpr_pkg::ACC_W-1:0]      div_num;
	logic [mcpr_pkg::ACC_W-1:0]      div_den;
	logic [mcpr_pkg::ACC_W-1:0]      div_quo;
	logic [mcpr_pkg::LEVEL_W-1:0]    rep_duty [mcpr_pkg::REPORT_CH];
	logic [3:0]                      rep_active;
	logic                            out_free;

	assign cur      = chans_q[ch_q];
	assign mask_ext = EXT_W'(mask_q);
	assign ctl      = {(CMP_W'(ch_q) == CMP_W'(chan_sel_q)), mask_ext[ch_q]};
	assign is_div   = (act_q == mcpr_pkg::ACT_PREP_RISE) || (act_q == mcpr_pkg::ACT_PREP_FALL);
	assign last_ch  = (ch_q == LAST_CH);
	assign out_free = !out_valid_q || !out_stall;

	mcpr_chan_alu u_alu (
		.op    (act_q),
		.ctl   (ctl),
		.level (level_q),
		.cur   (cur),
		.nxt   (nxt),
		.beep  (alu_beep)
	);

	assign div_start = (state_q == S_CHAN) && is_div;
	assign div_num   = (act_q == mcpr_pkg::ACT_PREP_RISE) ?
	                   {cur.target, {mcpr_pkg::FRAC_BITS{1'b0}}} :
	                   {cur.duty, {mcpr_pkg::FRAC_BITS{1'b0}}};
	always_comb begin
		if (act_q == mcpr_pkg::ACT_PREP_RISE)
			div_den = (rise_ticks_q == '0) ? mcpr_pkg::ACC_W'(1) : rise_ticks_q;
		else
			div_den = (fall_ticks_q == '0) ? mcpr_pkg::ACC_W'(1) : fall_ticks_q;
	end

	mcpr_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// absent channels report zero
	for (genvar g = 0; g < mcpr_pkg::REPORT_CH; g++) begin : g_rep
		if (g < NUM_CHANNELS) begin : g_on
			assign rep_duty[g] = chans_q[g].duty;
		end else begin : g_off
			assign rep_duty[g] = '0;
		end
		assign rep_active[g] = (rep_duty[g] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_ticks_q <= mcpr_pkg::TICKS_RST;
			fall_ticks_q <= mcpr_pkg::TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mcpr_pkg::CFG_RISE_TICKS: rise_ticks_q <= cfg_data;
				mcpr_pkg::CFG_FALL_TICKS: fall_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++)
				chans_q[i] <= '0;
		end else if (state_q == S_CHAN) begin
			chans_q[ch_q] <= nxt;
		end else if (state_q == S_DIV && div_done) begin
			if (act_q == mcpr_pkg::ACT_PREP_RISE)
				chans_q[ch_q].rise_inc <= div_quo;
			else
				chans_q[ch_q].fall_dec <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			act_q       <= mcpr_pkg::ACT_INC_ONE;
			chan_sel_q  <= '0;
			mask_q      <= '0;
			level_q     <= '0;
			beep_acc_q  <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= '0;
			beep_q      <= 1'b0;
			for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
				duty_out_q[i] <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q      <= mcpr_pkg::action_t'(action);
						chan_sel_q <= channel;
						mask_q     <= enable_mask;
						level_q    <= level;
						ch_q       <= '0;
						beep_acc_q <= 1'b0;
						state_q    <= S_CHAN;
					end
				end
				S_CHAN: begin
					beep_acc_q <= beep_acc_q | alu_beep;
					if (is_div) begin
						state_q <= S_DIV;
					end else if (last_ch) begin
						state_q <= S_DONE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (last_ch) begin
							state_q <= S_DONE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_CHAN;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
							duty_out_q[i] <= rep_duty[i];
						active_q    <= rep_active;
						beep_q      <= beep_acc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign duty_ch0    = duty_out_q[0];
	assign duty_ch1    = duty_out_q[1];
	assign duty_ch2    = duty_out_q[2];
	assign duty_ch3    = duty_out_q[3];
	assign active_mask = active_q;
	assign beep        = beep_q;

endmodule

FILE: sv/mcpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpr_checker
// Port-level checks on the power ramp, bound to the top level.
// ----------------------------------------------------------------------------
module mcpr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch0,
	input  logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch1,
	input  logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch2,
	input  logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch3,
	input  logic [3:0]                    active_mask
);

	// a result waiting on the sink is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request in flight: the input closes straight after acceptance
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_mask[0] == (duty_ch0 != '0)) &&
		              (active_mask[1] == (duty_ch1 != '0)) &&
		              (active_mask[2] == (duty_ch2 != '0)) &&
		              (active_mask[3] == (duty_ch3 != '0)))
		else $error("active mask disagrees with duties");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_ch0 <= mcpr_pkg::MAX_LEVEL) && (duty_ch1 <= mcpr_pkg::MAX_LEVEL) &&
		              (duty_ch2 <= mcpr_pkg::MAX_LEVEL) && (duty_ch3 <= mcpr_pkg::MAX_LEVEL))
		else $error("duty above full scale");

endmodule

bind multichannel_power_ramp mcpr_checker u_mcpr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.duty_ch0    (duty_ch0),
	.duty_ch1    (duty_ch1),
	.duty_ch2    (duty_ch2),
	.duty_ch3    (duty_ch3),
	.active_mask (active_mask)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel power ramp. Requests are queued by
// a stimulus process and offered by a clocked driver; a clocked monitor
// compares every result with a cycle-free model of the four channels. The run
// goes through several tick settings, random idling on both sides, a long
// output hold-off and full drains between settings.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [3:0]                   act;
		logic [1:0]                   ch;
		logic [3:0]                   en;
		logic [mcpr_pkg::LEVEL_W-1:0] lvl;
	} ramp_req_t;

	typedef struct packed {
		logic [3:0][mcpr_pkg::LEVEL_W-1:0] duty;
		logic [3:0]                        active;
		logic                              beep;
	} ramp_view_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_wr_en   = 1'b0;
	logic                          cfg_index   = mcpr_pkg::CFG_RISE_TICKS;
	logic [mcpr_pkg::TICK_W-1:0]   cfg_data    = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic [3:0]                    action      = '0;
	logic [1:0]                    channel     = '0;
	logic [3:0]                    enable_mask = '0;
	logic [mcpr_pkg::LEVEL_W-1:0]  level       = '0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [mcpr_pkg::LEVEL_W-1:0]  duty_ch0, duty_ch1, duty_ch2, duty_ch3;
	logic [3:0]                    active_mask;
	logic                          beep;

	multichannel_power_ramp DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .channel(channel), .enable_mask(enable_mask), .level(level),
		.out_valid(out_valid), .out_stall(out_stall),
		.duty_ch0(duty_ch0), .duty_ch1(duty_ch1), .duty_ch2(duty_ch2), .duty_ch3(duty_ch3),
		.active_mask(active_mask), .beep(beep)
	);

	always #5 clk = ~clk;

	// model state, one entry per channel
	logic [mcpr_pkg::LEVEL_W-1:0] tgt_lvl[mcpr_pkg::REPORT_CH];
	logic [mcpr_pkg::LEVEL_W-1:0] cur_duty[mcpr_pkg::REPORT_CH];
	logic [mcpr_pkg::ACC_W-1:0]   ramp_acc[mcpr_pkg::REPORT_CH];
	logic [mcpr_pkg::ACC_W-1:0]   up_step[mcpr_pkg::REPORT_CH];
	logic [mcpr_pkg::ACC_W-1:0]   down_step[mcpr_pkg::REPORT_CH];
	logic [mcpr_pkg::TICK_W-1:0]  rise_ticks_cfg;
	logic [mcpr_pkg::TICK_W-1:0]  fall_ticks_cfg;

	ramp_req_t  request_q[$];
	ramp_view_t duty_expect_q[$];
	int         mismatches = 0;
	int         queued = 0;
	bit         calm = 1'b0;
	int         hold_asked = 0;
	int         hold_given = 0;
	int         hold_left = 0;

	function automatic bit nudge_target(int ch, bit up);
		if (up) begin
			if (tgt_lvl[ch] < mcpr_pkg::MAX_LEVEL) begin
				tgt_lvl[ch] = tgt_lvl[ch] + 1'b1;
				return 1'b0;
			end
			return 1'b1;
		end
		if (tgt_lvl[ch] != '0) begin
			tgt_lvl[ch] = tgt_lvl[ch] - 1'b1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic ramp_view_t predict_ramp(logic [3:0] act, logic [1:0] ch,
			logic [3:0] en, logic [mcpr_pkg::LEVEL_W-1:0] lvl);
		ramp_view_t                   view;
		logic [mcpr_pkg::TICK_W-1:0]  rise_div;
		logic [mcpr_pkg::TICK_W-1:0]  fall_div;
		logic [mcpr_pkg::ACC_W:0]     sum;
		logic [mcpr_pkg::LEVEL_W-1:0] whole;
		view = '0;
		// a zero tick count divides as one
		rise_div = (rise_ticks_cfg == '0) ? 16'd1 : rise_ticks_cfg;
		fall_div = (fall_ticks_cfg == '0) ? 16'd1 : fall_ticks_cfg;
		case (act)
			mcpr_pkg::ACT_INC_ONE: view.beep = nudge_target(ch, 1'b1);
			mcpr_pkg::ACT_DEC_ONE: view.beep = nudge_target(ch, 1'b0);
			mcpr_pkg::ACT_INC_ALL, mcpr_pkg::ACT_DEC_ALL: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
					if (nudge_target(i, act == mcpr_pkg::ACT_INC_ALL))
						view.beep = 1'b1;
			end
			mcpr_pkg::ACT_PREP_RISE: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++) begin
					up_step[i] = mcpr_pkg::ACC_W'((32'(tgt_lvl[i]) << mcpr_pkg::FRAC_BITS)
						/ 32'(rise_div));
					ramp_acc[i] = '0;
				end
			end
			mcpr_pkg::ACT_PREP_FALL: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++) begin
					ramp_acc[i] = mcpr_pkg::ACC_W'(32'(cur_duty[i]) << mcpr_pkg::FRAC_BITS);
					down_step[i] = ramp_acc[i] / fall_div;
				end
			end
			mcpr_pkg::ACT_RISE_TICK: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
					if (en[i]) begin
						sum = {1'b0, ramp_acc[i]} + {1'b0, up_step[i]};
						ramp_acc[i] = sum[mcpr_pkg::ACC_W] ? mcpr_pkg::ACC_MAX
							: sum[mcpr_pkg::ACC_W-1:0];
						whole = ramp_acc[i][mcpr_pkg::ACC_W-1:mcpr_pkg::FRAC_BITS];
						if (whole <= tgt_lvl[i])
							cur_duty[i] = whole;
					end
			end
			mcpr_pkg::ACT_FALL_TICK: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++) begin
					ramp_acc[i] = (ramp_acc[i] > down_step[i]) ? ramp_acc[i] - down_step[i] : '0;
					whole = ramp_acc[i][mcpr_pkg::ACC_W-1:mcpr_pkg::FRAC_BITS];
					cur_duty[i] = (whole > mcpr_pkg::MAX_LEVEL) ? mcpr_pkg::MAX_LEVEL : whole;
				end
			end
			mcpr_pkg::ACT_APPLY: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
					if (en[i])
						cur_duty[i] = tgt_lvl[i];
			end
			mcpr_pkg::ACT_SET_ALL: begin
				for (int i = 0; i < mcpr_pkg::REPORT_CH; i++)
					cur_duty[i] = (lvl > mcpr_pkg::MAX_LEVEL) ? mcpr_pkg::MAX_LEVEL : lvl;
			end
			default: ;
		endcase
		for (int i = 0; i < mcpr_pkg::REPORT_CH; i++) begin
			view.duty[i] = cur_duty[i];
			view.active[i] = (cur_duty[i] != '0);
		end
		return view;
	endfunction

	// driver: one request held on the port until taken
	always @(posedge clk) begin
		ramp_req_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				duty_expect_q.push_back(predict_ramp(action, channel, enable_mask, level));
			if (!in_valid || !in_stall) begin
				if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
					nxt = request_q.pop_front();
					in_valid <= 1'b1;
					action <= nxt.act;
					channel <= nxt.ch;
					enable_mask <= nxt.en;
					level <= nxt.lvl;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and output back-pressure
	always @(posedge clk) begin
		ramp_view_t seen;
		ramp_view_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.duty = {duty_ch3, duty_ch2, duty_ch1, duty_ch0};
				seen.active = active_mask;
				seen.beep = beep;
				if (duty_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request outstanding: duty %0d/%0d/%0d/%0d",
							$realtime, duty_ch0, duty_ch1, duty_ch2, duty_ch3);
				end else begin
					want = duty_expect_q.pop_front();
					if (seen.duty !== want.duty || seen.active !== want.active
							|| seen.beep !== want.beep) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: duty exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d, ",
								"active exp %b got %b, beep exp %b got %b"}, $realtime,
								want.duty[0], want.duty[1], want.duty[2], want.duty[3],
								seen.duty[0], seen.duty[1], seen.duty[2], seen.duty[3],
								want.active, seen.active, want.beep, seen.beep);
					end
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_asked != hold_given) begin
				out_stall <= 1'b1;
				hold_given <= hold_given + 1;
				hold_left <= 400;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 37);
			end
		end
	end

	task automatic queue_request(logic [3:0] act, logic [1:0] ch, logic [3:0] en,
			logic [mcpr_pkg::LEVEL_W-1:0] lvl);
		ramp_req_t r;
		r.act = act;
		r.ch = ch;
		r.en = en;
		r.lvl = lvl;
		request_q.push_back(r);
		queued++;
	endtask

	task automatic rand_request(logic [3:0] act, logic [3:0] en);
		queue_request(act, 2'($urandom_range(0, 3)), en, 7'($urandom_range(0, 127)));
	endtask

	function automatic logic [3:0] pick_mask();
		return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
	endfunction

	task automatic random_traffic(int count);
		int start;
		int kind;
		int len;
		start = queued;
		while (queued - start < count) begin
			kind = $urandom_range(0, 99);
			len = $urandom_range(1, 8);
			if (kind < 20) begin
				repeat (len) rand_request(4'($urandom_range(mcpr_pkg::ACT_INC_ONE,
					mcpr_pkg::ACT_DEC_ALL)), pick_mask());
			end else if (kind < 42) begin
				rand_request(mcpr_pkg::ACT_PREP_RISE, pick_mask());
				repeat ($urandom_range(1, 40)) rand_request(mcpr_pkg::ACT_RISE_TICK, pick_mask());
			end else if (kind < 60) begin
				rand_request(mcpr_pkg::ACT_PREP_FALL, pick_mask());
				repeat ($urandom_range(1, 40)) rand_request(mcpr_pkg::ACT_FALL_TICK, pick_mask());
			end else if (kind < 72) begin
				rand_request($urandom_range(0, 1) ? mcpr_pkg::ACT_APPLY : mcpr_pkg::ACT_SET_ALL,
					pick_mask());
			end else if (kind < 78) begin
				// low duty and small fall step, then a rise run into the accumulator ceiling
				queue_request(mcpr_pkg::ACT_SET_ALL, 2'($urandom_range(0, 3)), pick_mask(),
					7'($urandom_range(0, 20)));
				rand_request(mcpr_pkg::ACT_PREP_FALL, pick_mask());
				rand_request(mcpr_pkg::ACT_PREP_RISE, pick_mask());
				repeat ($urandom_range(1, 4)) rand_request(mcpr_pkg::ACT_RISE_TICK, 4'hF);
				repeat ($urandom_range(1, 3)) rand_request(mcpr_pkg::ACT_FALL_TICK, pick_mask());
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 4))
					rand_request(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			end else begin
				len = $urandom_range(30, 110);
				kind = $urandom_range(0, 3);
				repeat (len) rand_request((kind != 0) ? mcpr_pkg::ACT_INC_ALL
					: mcpr_pkg::ACT_DEC_ALL, pick_mask());
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (request_q.size() != 0 || in_valid || duty_expect_q.size() != 0);
	endtask

	task automatic write_ticks(logic [mcpr_pkg::TICK_W-1:0] rise,
			logic [mcpr_pkg::TICK_W-1:0] fall);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= mcpr_pkg::CFG_RISE_TICKS;
		cfg_data <= rise;
		rise_ticks_cfg = rise;
		@(posedge clk);
		cfg_index <= mcpr_pkg::CFG_FALL_TICKS;
		cfg_data <= fall;
		fall_ticks_cfg = fall;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [mcpr_pkg::TICK_W-1:0] rise,
			logic [mcpr_pkg::TICK_W-1:0] fall, int count);
		drain();
		write_ticks(rise, fall);
		random_traffic(count);
	endtask

	initial begin
		for (int i = 0; i < mcpr_pkg::REPORT_CH; i++) begin
			tgt_lvl[i] = '0;
			cur_duty[i] = '0;
			ramp_acc[i] = '0;
			up_step[i] = '0;
			down_step[i] = '0;
		end
		rise_ticks_cfg = mcpr_pkg::TICKS_RST;
		fall_ticks_cfg = mcpr_pkg::TICKS_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests at reset tick counts
		queue_request(mcpr_pkg::ACT_DEC_ONE,   2'd0, 4'h0, 7'd0);
		queue_request(mcpr_pkg::ACT_DEC_ALL,   2'd3, 4'hF, 7'd127);
		queue_request(mcpr_pkg::ACT_INC_ONE,   2'd3, 4'h0, 7'd127);
		queue_request(mcpr_pkg::ACT_INC_ALL,   2'd0, 4'hF, 7'd0);
		queue_request(mcpr_pkg::ACT_SET_ALL,   2'd1, 4'h5, 7'd127);
		queue_request(mcpr_pkg::ACT_PREP_FALL, 2'd2, 4'hA, 7'd64);
		queue_request(mcpr_pkg::ACT_FALL_TICK, 2'd0, 4'hF, 7'd0);
		queue_request(mcpr_pkg::ACT_SET_ALL,   2'd3, 4'h0, 7'd0);
		queue_request(mcpr_pkg::ACT_SET_ALL,   2'd0, 4'hF, 7'd100);
		queue_request(mcpr_pkg::ACT_PREP_RISE, 2'd1, 4'h3, 7'd33);
		queue_request(mcpr_pkg::ACT_RISE_TICK, 2'd0, 4'hF, 7'd0);
		queue_request(mcpr_pkg::ACT_RISE_TICK, 2'd2, 4'h6, 7'd0);
		queue_request(mcpr_pkg::ACT_APPLY,     2'd0, 4'hA, 7'd0);
		queue_request(mcpr_pkg::ACT_APPLY,     2'd3, 4'hF, 7'd127);
		queue_request(mcpr_pkg::ACT_APPLY,     2'd0, 4'h0, 7'd0);
		queue_request(4'd10,                   2'd2, 4'hF, 7'd127);
		queue_request(4'd15,                   2'd3, 4'hF, 7'd127);

		run_phase(16'd1, 16'd1, 330);

		// no idling here, and a long output hold-off while requests keep coming
		drain();
		write_ticks(16'hFFFF, 16'hFFFF);
		calm = 1'b1;
		hold_asked = hold_asked + 1;
		random_traffic(330);
		drain();
		calm = 1'b0;

		run_phase(16'd0, 16'd0, 330);
		run_phase(16'd7, 16'd13, 330);
		run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)), 330);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 330);

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("[multichannel_power_ramp] OK");
		else
			$display("[multichannel_power_ramp] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("[multichannel_power_ramp] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/mcpr_pkg.sv
sv/mcpr_serial_div.sv
sv/mcpr_chan_alu.sv
sv/multichannel_power_ramp.sv
sv/mcpr_checker.sv
bench/tb.sv
